// File: rtl/cau_pkg.sv
package cau_pkg;

   // Operand and result format.
   localparam int DW = 16;
   localparam int FB = 8;

   // Derived widths.
   localparam int CMDW = 2;
   localparam int ASW = DW + 1;
   localparam int PW = 2 * DW;
   localparam int SW = 2 * DW + 1;
   localparam int MAGW = SW;
   localparam int DENW = 2 * DW;
   localparam int NXW = MAGW + FB;
   localparam int CMPW = 3 * DW + FB + 1;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_W = CMDW + 4 * DW;
   localparam int REQ_TDATA_W = ((REQ_W + 7) / 8) * 8;
   localparam int RSP_W = 2 * DW + 2;
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8;

   // Operation codes.
   localparam logic [CMDW-1:0] CMD_ADD = 2'd0;
   localparam logic [CMDW-1:0] CMD_SUB = 2'd1;
   localparam logic [CMDW-1:0] CMD_MUL = 2'd2;
   localparam logic [CMDW-1:0] CMD_DIV = 2'd3;

   typedef struct packed {
      logic [DW-1:0] val;
      logic          ovf;
   } sat_type;

   typedef struct packed {
      logic          dz;
      logic          ovf;
      logic [DW-1:0] im;
      logic [DW-1:0] re;
   } res_type;

   // One item as it travels through the divider stages.
   typedef struct packed {
      logic            is_div;
      logic            dz;
      logic            neg_re;
      logic            neg_im;
      logic            big_re;
      logic            big_im;
      logic [DENW-1:0] rem_re;
      logic [DENW-1:0] rem_im;
      logic [DW-1:0]   nlo_re;
      logic [DW-1:0]   nlo_im;
      logic [DW-1:0]   q_re;
      logic [DW-1:0]   q_im;
      logic [DENW-1:0] den;
      logic [DW-1:0]   dres_re;
      logic [DW-1:0]   dres_im;
      logic            dovf;
   } item_type;

   // Clamp a sign and magnitude to the signed DW range.
   function automatic sat_type saturate(input logic neg, input logic [MAGW-1:0] mag);
      sat_type         r;
      logic [MAGW-1:0] lim;
      logic [MAGW-1:0] m;
      logic [MAGW-1:0] negm;
      lim = {{(MAGW-DW){1'b0}}, 1'b0, {(DW-1){1'b1}}} + MAGW'(neg);
      if (mag > lim) begin
         m = lim;
         r.ovf = 1'b1;
      end else begin
         m = mag;
         r.ovf = 1'b0;
      end
      negm = ~m + 1'b1;
      r.val = neg ? negm[DW-1:0] : m[DW-1:0];
      return r;
   endfunction

   // Magnitude of a signed sum.
   function automatic logic [MAGW-1:0] magnitude(input logic [SW-1:0] v);
      logic [SW-1:0] t;
      t = ~v + 1'b1;
      return v[SW-1] ? t : v;
   endfunction

endpackage

// File: rtl/complex_arith_unit.sv
// Complex add, subtract, multiply and divide on signed fixed-point operands.
//
// Request channel (req_*): one transfer carries a command and two complex
// operands. Response channel (rsp_*): one transfer per request, in order,
// carrying the saturated complex result and the overflow and divide-by-zero
// flags.
//
// From the request transfer to rsp_tvalid, three stages form products, sums
// and the divider setup, one restoring divider stage per quotient bit
// follows, and one output register.
// Every command takes the same path, so results stay in order. Throughput is
// one item per cycle while the receiver does not stall; the per-bit divider stages set the depth.
//
// Reset is synchronous and empties every stage and the output register.
// When the receiver stalls, the output register holds its result and one more
// result is kept in a skid entry; req_tready then drops and the whole
// pipeline holds until the response side drains.
module complex_arith_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // cmd, a_real, a_imag, b_real, b_imag (lowest bits first), zero padded
   input  logic [cau_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // res_real, res_imag, overflow, div_zero (lowest bits first), zero padded
   output logic [cau_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int DW = cau_pkg::DW;
   localparam int CMDW = cau_pkg::CMDW;

   logic                        en;
   logic                        stg_valid [0:DW];
   cau_pkg::item_type           stg_item [0:DW];
   cau_pkg::res_type            res;

   // Request field unpacking.
   logic [CMDW-1:0]             cmd;
   logic signed [DW-1:0]        a_real, a_imag, b_real, b_imag;

   assign cmd = req_tdata[CMDW-1:0];
   assign a_real = $signed(req_tdata[CMDW +: DW]);
   assign a_imag = $signed(req_tdata[CMDW + DW +: DW]);
   assign b_real = $signed(req_tdata[CMDW + 2*DW +: DW]);
   assign b_imag = $signed(req_tdata[CMDW + 3*DW +: DW]);

   assign req_tready = en;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .cmd       (cmd),
      .a_real    (a_real),
      .a_imag    (a_imag),
      .b_real    (b_real),
      .b_imag    (b_imag),
      .out_valid (stg_valid[0]),
      .out_item  (stg_item[0])
   );

   // One divider stage per quotient bit.
   genvar gi;
   generate
      for (gi = 0; gi < DW; gi++) begin : g_div
         cau_div_step u_step (
            .clock     (clock),
            .reset     (reset),
            .en        (en),
            .in_valid  (stg_valid[gi]),
            .in_item   (stg_item[gi]),
            .out_valid (stg_valid[gi+1]),
            .out_item  (stg_item[gi+1])
         );
      end
   endgenerate

   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[DW]),
      .in_item   (stg_item[DW]),
      .en        (en),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (res)
   );

   assign rsp_tdata = cau_pkg::RSP_TDATA_W'({res.dz, res.ovf, res.im, res.re});

endmodule

// File: rtl/cau_front.sv
module cau_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [cau_pkg::CMDW-1:0]       cmd,
   input  logic signed [cau_pkg::DW-1:0]  a_real,
   input  logic signed [cau_pkg::DW-1:0]  a_imag,
   input  logic signed [cau_pkg::DW-1:0]  b_real,
   input  logic signed [cau_pkg::DW-1:0]  b_imag,
   output logic                           out_valid,
   output cau_pkg::item_type              out_item
);

   localparam int DW = cau_pkg::DW;
   localparam int PW = cau_pkg::PW;
   localparam int SW = cau_pkg::SW;
   localparam int ASW = cau_pkg::ASW;
   localparam int DENW = cau_pkg::DENW;
   localparam int MAGW = cau_pkg::MAGW;
   localparam int NXW = cau_pkg::NXW;
   localparam int CMPW = cau_pkg::CMPW;
   localparam int FB = cau_pkg::FB;

   // Stage 1: products and the add/subtract sums.
   logic                        s1_valid_ff;
   logic [cau_pkg::CMDW-1:0]    s1_cmd_ff;
   logic signed [PW-1:0]        s1_rr_ff, s1_ii_ff, s1_ri_ff, s1_ir_ff, s1_brr_ff, s1_bii_ff;
   logic signed [ASW-1:0]       s1_sre_ff, s1_sim_ff;
   logic signed [ASW-1:0]       s1_sre_in, s1_sim_in;

   always_comb begin
      if (cmd == cau_pkg::CMD_SUB) begin
         s1_sre_in = ASW'(a_real) - ASW'(b_real);
         s1_sim_in = ASW'(a_imag) - ASW'(b_imag);
      end else begin
         s1_sre_in = ASW'(a_real) + ASW'(b_real);
         s1_sim_in = ASW'(a_imag) + ASW'(b_imag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_cmd_ff <= cmd;
         s1_rr_ff <= PW'(a_real) * PW'(b_real);
         s1_ii_ff <= PW'(a_imag) * PW'(b_imag);
         s1_ri_ff <= PW'(a_real) * PW'(b_imag);
         s1_ir_ff <= PW'(a_imag) * PW'(b_real);
         s1_brr_ff <= PW'(b_real) * PW'(b_real);
         s1_bii_ff <= PW'(b_imag) * PW'(b_imag);
         s1_sre_ff <= s1_sre_in;
         s1_sim_ff <= s1_sim_in;
      end
   end

   // Stage 2: numerators and the divisor.
   logic                        s2_valid_ff;
   logic [cau_pkg::CMDW-1:0]    s2_cmd_ff;
   logic signed [SW-1:0]        s2_nre_ff, s2_nim_ff, s2_nre_in, s2_nim_in;
   logic [DENW-1:0]             s2_den_ff, s2_den_in;

   always_comb begin
      case (s1_cmd_ff)
         cau_pkg::CMD_MUL: begin
            s2_nre_in = SW'(s1_rr_ff) - SW'(s1_ii_ff);
            s2_nim_in = SW'(s1_ri_ff) + SW'(s1_ir_ff);
         end
         cau_pkg::CMD_DIV: begin
            s2_nre_in = SW'(s1_rr_ff) + SW'(s1_ii_ff);
            s2_nim_in = SW'(s1_ir_ff) - SW'(s1_ri_ff);
         end
         default: begin
            s2_nre_in = SW'(s1_sre_ff);
            s2_nim_in = SW'(s1_sim_ff);
         end
      endcase
      s2_den_in = DENW'($unsigned(s1_brr_ff)) + DENW'($unsigned(s1_bii_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_nre_ff <= s2_nre_in;
         s2_nim_ff <= s2_nim_in;
         s2_den_ff <= s2_den_in;
      end
   end

   // Stage 3: sign and magnitude, direct results, divider setup.
   logic                        s3_valid_ff;
   cau_pkg::item_type           s3_item_ff, s3_item_in;
   logic [MAGW-1:0]             mag_re, mag_im, dmag_re, dmag_im;
   logic [NXW-1:0]              nx_re, nx_im;
   logic [CMPW-1:0]             den_top;
   cau_pkg::sat_type            sat_re, sat_im;
   logic                        is_mul;

   always_comb begin
      is_mul = (s2_cmd_ff == cau_pkg::CMD_MUL);
      mag_re = cau_pkg::magnitude(s2_nre_ff);
      mag_im = cau_pkg::magnitude(s2_nim_ff);
      dmag_re = is_mul ? (mag_re >> FB) : mag_re;
      dmag_im = is_mul ? (mag_im >> FB) : mag_im;
      sat_re = cau_pkg::saturate(s2_nre_ff[SW-1], dmag_re);
      sat_im = cau_pkg::saturate(s2_nim_ff[SW-1], dmag_im);
      nx_re = NXW'(mag_re) << FB;
      nx_im = NXW'(mag_im) << FB;
      den_top = CMPW'(s2_den_ff) << DW;

      s3_item_in.is_div = (s2_cmd_ff == cau_pkg::CMD_DIV);
      s3_item_in.dz = (s2_den_ff == '0);
      s3_item_in.neg_re = s2_nre_ff[SW-1];
      s3_item_in.neg_im = s2_nim_ff[SW-1];
      s3_item_in.big_re = (CMPW'(nx_re) >= den_top);
      s3_item_in.big_im = (CMPW'(nx_im) >= den_top);
      s3_item_in.rem_re = DENW'(nx_re >> DW);
      s3_item_in.rem_im = DENW'(nx_im >> DW);
      s3_item_in.nlo_re = nx_re[DW-1:0];
      s3_item_in.nlo_im = nx_im[DW-1:0];
      s3_item_in.q_re = '0;
      s3_item_in.q_im = '0;
      s3_item_in.den = s2_den_ff;
      s3_item_in.dres_re = sat_re.val;
      s3_item_in.dres_im = sat_im.val;
      s3_item_in.dovf = sat_re.ovf | sat_im.ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item = s3_item_ff;

endmodule

// File: rtl/cau_div_step.sv
module cau_div_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  cau_pkg::item_type in_item,
   output logic              out_valid,
   output cau_pkg::item_type out_item
);

   localparam int DW = cau_pkg::DW;
   localparam int DENW = cau_pkg::DENW;

   logic                 valid_ff;
   cau_pkg::item_type    item_ff, item_in;
   logic [DENW:0]        r2_re, r2_im, d_ext;
   logic [DENW:0]        diff_re, diff_im;
   logic                 ge_re, ge_im;

   // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      d_ext = {1'b0, in_item.den};
      r2_re = {in_item.rem_re, in_item.nlo_re[DW-1]};
      r2_im = {in_item.rem_im, in_item.nlo_im[DW-1]};
      ge_re = (r2_re >= d_ext);
      ge_im = (r2_im >= d_ext);
      diff_re = r2_re - d_ext;
      diff_im = r2_im - d_ext;

      item_in = in_item;
      item_in.rem_re = ge_re ? diff_re[DENW-1:0] : r2_re[DENW-1:0];
      item_in.rem_im = ge_im ? diff_im[DENW-1:0] : r2_im[DENW-1:0];
      item_in.nlo_re = in_item.nlo_re << 1;
      item_in.nlo_im = in_item.nlo_im << 1;
      item_in.q_re = {in_item.q_re[DW-2:0], ge_re};
      item_in.q_im = {in_item.q_im[DW-2:0], ge_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule

// File: rtl/cau_back.sv
module cau_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cau_pkg::item_type in_item,
   output logic              en,
   output logic              out_valid,
   input  logic              out_ready,
   output cau_pkg::res_type  out_res
);

   localparam int MAGW = cau_pkg::MAGW;

   logic                 out_valid_ff, skid_valid_ff;
   cau_pkg::res_type     out_res_ff, skid_res_ff, fin;
   cau_pkg::sat_type     q_re, q_im;
   logic                 take;

   // Final sign and saturation of the quotient, or the direct result.
   always_comb begin
      q_re = cau_pkg::saturate(in_item.neg_re, MAGW'({in_item.big_re, in_item.q_re}));
      q_im = cau_pkg::saturate(in_item.neg_im, MAGW'({in_item.big_im, in_item.q_im}));
      if (!in_item.is_div) begin
         fin.re = in_item.dres_re;
         fin.im = in_item.dres_im;
         fin.ovf = in_item.dovf;
         fin.dz = 1'b0;
      end else if (in_item.dz) begin
         fin.re = '0;
         fin.im = '0;
         fin.ovf = 1'b0;
         fin.dz = 1'b1;
      end else begin
         fin.re = q_re.val;
         fin.im = q_im.val;
         fin.ovf = q_re.ovf | q_im.ovf;
         fin.dz = 1'b0;
      end
   end

   assign en = !skid_valid_ff;
   assign take = out_valid_ff && out_ready;

   // Output register with one skid entry; the pipeline freezes while the skid entry is full.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_res_ff <= skid_res_ff;
            out_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_res_ff <= fin;
            out_valid_ff <= in_valid;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_res_ff <= fin;
         skid_valid_ff <= 1'b1;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_res = out_res_ff;

endmodule

// File: rtl/cau_checker.sv
module cau_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [cau_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int DW = cau_pkg::DW;
   localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MAX_NEG = {1'b1, {(DW-1){1'b0}}};

   logic [DW-1:0] res_re, res_im;
   logic          ovf, dz;

   assign res_re = rsp_tdata[DW-1:0];
   assign res_im = rsp_tdata[2*DW-1:DW];
   assign ovf = rsp_tdata[2*DW];
   assign dz = rsp_tdata[2*DW+1];

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Nothing comes out in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // The request side is open right after reset.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request side not ready after reset");

   // A divide by zero gives a zero result without overflow.
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && dz |-> res_re == '0 && res_im == '0 && !ovf)
      else $error("divide by zero result not cleared");

   // An overflow leaves at least one part at a range limit.
   a_ovf_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ovf |-> res_re == MAX_POS || res_re == MAX_NEG
                            || res_im == MAX_POS || res_im == MAX_NEG)
      else $error("overflow flagged without a clamped part");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int DW = cau_pkg::DW;
   localparam int FB = cau_pkg::FB;
   localparam int CMDW = cau_pkg::CMDW;
   localparam int REQ_TDATA_W = cau_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = cau_pkg::RSP_TDATA_W;

   typedef struct packed {
      logic [CMDW-1:0] cmd;
      logic [DW-1:0]   ar;
      logic [DW-1:0]   ai;
      logic [DW-1:0]   br;
      logic [DW-1:0]   bi;
   } operands_type;

   typedef struct packed {
      logic [DW-1:0] re;
      logic [DW-1:0] im;
      logic          ovf;
      logic          dz;
   } cresult_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   operands_type pending_ops[$];
   cresult_type  expected_results[$];
   int        send_idle_pct;
   int        recv_idle_pct;
   int        recv_hold;
   bit        send_pause;
   int        quiet_cycles;
   int        error_count;
   int        sent_count;
   int        checked_count;
   int        dz_count;
   int        ovf_count;

   localparam int WATCHDOG_LIMIT = 20000;

   complex_arith_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock with a 12 ns period.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Clamp a wide signed value to the operand range and note any clamping.
   function automatic logic [DW-1:0] clamp_part(input longint v, inout logic ovf);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (DW - 1)) - 1;
      lo = -(64'sd1 <<< (DW - 1));
      if (v > hi) begin
         ovf = 1'b1;
         return DW'(hi);
      end
      if (v < lo) begin
         ovf = 1'b1;
         return DW'(lo);
      end
      return DW'(v);
   endfunction

   // Quotient scaled by 2^FB, truncated toward zero.
   function automatic longint scaled_divide(input longint num, input longint den);
      longint q;
      logic   neg;
      neg = (num < 0);
      if (neg) num = -num;
      q = (num <<< FB) / den;
      return neg ? -q : q;
   endfunction

   // Expected complex result of one command.
   function automatic cresult_type complex_result(input operands_type op);
      cresult_type r;
      longint   ar, ai, br, bi, re, im, den;
      ar = longint'($signed(op.ar));
      ai = longint'($signed(op.ai));
      br = longint'($signed(op.br));
      bi = longint'($signed(op.bi));
      r.ovf = 1'b0;
      r.dz = 1'b0;
      re = 0;
      im = 0;
      case (op.cmd)
         cau_pkg::CMD_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         cau_pkg::CMD_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         cau_pkg::CMD_MUL: begin
            re = ar * br - ai * bi;
            im = ar * bi + ai * br;
            // Truncate the magnitude, so negative values round toward zero.
            re = (re < 0) ? -((-re) >>> FB) : (re >>> FB);
            im = (im < 0) ? -((-im) >>> FB) : (im >>> FB);
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               re = scaled_divide(ar * br + ai * bi, den);
               im = scaled_divide(ai * br - ar * bi, den);
            end
         end
      endcase
      r.re = clamp_part(re, r.ovf);
      r.im = clamp_part(im, r.ovf);
      return r;
   endfunction

   function automatic logic [DW-1:0] rand_part();
      case ($urandom_range(0, 7))
         0: return {1'b0, {(DW-1){1'b1}}};
         1: return {1'b1, {(DW-1){1'b0}}};
         2: return DW'($urandom_range(0, 3)) - DW'(1);
         3: return DW'($signed(DW'($urandom_range(0, 1023))) - 512);
         default: return DW'($urandom);
      endcase
   endfunction

   task automatic queue_op(input logic [CMDW-1:0] cmd, input logic [DW-1:0] ar,
                           input logic [DW-1:0] ai, input logic [DW-1:0] br,
                           input logic [DW-1:0] bi);
      operands_type op;
      op.cmd = cmd;
      op.ar = ar;
      op.ai = ai;
      op.br = br;
      op.bi = bi;
      pending_ops.push_back(op);
   endtask

   task automatic queue_random(input int n);
      operands_type op;
      for (int i = 0; i < n; i++) begin
         op.cmd = CMDW'($urandom_range(0, 3));
         op.ar = rand_part();
         op.ai = rand_part();
         op.br = rand_part();
         op.bi = rand_part();
         // Some divides by zero.
         if (op.cmd == cau_pkg::CMD_DIV && $urandom_range(0, 19) == 0) begin
            op.br = '0;
            op.bi = '0;
         end
         pending_ops.push_back(op);
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Driver: offer the next pending item, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            sent_count <= sent_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_ops.size() != 0 && !send_pause &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               operands_type op;
               op = pending_ops.pop_front();
               expected_results.push_back(complex_result(op));
               req_tdata <= REQ_TDATA_W'({op.bi, op.br, op.ai, op.ar, op.cmd});
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver readiness, with an optional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: compare each response transfer with the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            cresult_type exp_r;
            cresult_type got;
            got.re = rsp_tdata[DW-1:0];
            got.im = rsp_tdata[2*DW-1:DW];
            got.ovf = rsp_tdata[2*DW];
            got.dz = rsp_tdata[2*DW+1];
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response re=%h im=%h", $time, got.re, got.im);
               error_count <= error_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (got != exp_r) begin
                  $display(
                     "%0t: mismatch expected re=%h im=%h ovf=%b dz=%b, got re=%h im=%h ovf=%b dz=%b",
                     $time, exp_r.re, exp_r.im, exp_r.ovf, exp_r.dz,
                     got.re, got.im, got.ovf, got.dz);
                  error_count <= error_count + 1;
               end
               if (exp_r.dz) dz_count <= dz_count + 1;
               if (exp_r.ovf) ovf_count <= ovf_count + 1;
               checked_count <= checked_count + 1;
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel, outside reset and the receiver hold-off.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || recv_hold > 0)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", expected_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [DW-1:0] maxp;
      logic [DW-1:0] minp;
      maxp = {1'b0, {(DW-1){1'b1}}};
      minp = {1'b1, {(DW-1){1'b0}}};
      reset = 1'b1;
      send_idle_pct = 10;
      recv_idle_pct = 67;
      recv_hold = 0;
      send_pause = 1'b0;
      quiet_cycles = 0;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      dz_count = 0;
      ovf_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: every command at the extremes, divide by zero, overflow.
      for (int c = 0; c < 4; c++) begin
         queue_op(CMDW'(c), maxp, maxp, maxp, maxp);
         queue_op(CMDW'(c), minp, minp, minp, minp);
         queue_op(CMDW'(c), maxp, minp, minp, maxp);
         queue_op(CMDW'(c), 16'h0100, 16'hff00, 16'h0080, 16'hffff);
      end
      queue_op(cau_pkg::CMD_DIV, 16'h1234, 16'h8765, 16'h0000, 16'h0000);
      queue_op(cau_pkg::CMD_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      queue_op(cau_pkg::CMD_DIV, maxp, maxp, 16'h0001, 16'h0000);
      queue_op(cau_pkg::CMD_DIV, 16'hffff, 16'h0001, 16'h0000, 16'h0001);
      queue_op(cau_pkg::CMD_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
      queue_op(cau_pkg::CMD_SUB, minp, 16'h0000, 16'h0001, 16'h0000);
      queue_op(cau_pkg::CMD_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      queue_random(250);
      wait_drained();

      // Receiver holds off while items queue up; after the drain the sender pauses, then resumes.
      send_idle_pct = 67;
      recv_idle_pct = 10;
      queue_random(100);
      recv_hold <= 300;
      wait_drained();
      send_pause = 1'b1;
      repeat (30) @(posedge clock);
      send_pause = 1'b0;
      queue_random(250);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(330);
      wait_drained();
      repeat (40) @(posedge clock);

      $display("Sent %0d requests and checked %0d results over all four commands;",
               sent_count, checked_count);
      $display("%0d saturated, %0d divides by zero.", ovf_count, dz_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div_step.sv
rtl/cau_back.sv
rtl/complex_arith_unit.sv
rtl/cau_checker.sv
tb/tb.sv
